// ----- design/brfc_pkg.sv -----
package brfc_pkg;

  localparam int BRFC_CAPACITY  = 1024;
  localparam int BRFC_MAX_CHUNK = 64;

  localparam int REQ_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DEQ  = 2'd2,
    KIND_CLR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

endpackage

// ----- design/brfc_store.sv -----
module brfc_store
  import brfc_pkg::*;
#(
  parameter int DEPTH = BRFC_CAPACITY
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [BYTE_W-1:0]          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [BYTE_W-1:0]          rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/byte_ring_fifo_chunked_unit.sv -----
// channel | ports                   | contents
// --------+-------------------------+-------------------------------------------------
// in      | in_tvalid/in_tready     | tuser: kind
//         | in_tdata[23:0]          | request_size, partial_ok, peek, data_byte
// out     | out_tvalid/out_tready   | tuser: has_data, tlast: last
//         | out_tdata[39:0]         | ok, granted_count, out_byte, used_count, free_count
//
// Enqueue, data byte and clear words, and a refused or empty dequeue, load their result
// into the output register as they are accepted.
// A granted dequeue is accepted, then per byte the unit reads the byte store (ST_RD) and
// loads the output register (ST_OUT), which waits while the output is stalled.
// rst_n (synchronous) empties the queue; store contents stay undefined.
// A stalled out_tready holds the output register and blocks new input words.
module byte_ring_fifo_chunked_unit
  import brfc_pkg::*;
#(
  parameter int CAPACITY  = BRFC_CAPACITY,
  parameter int MAX_CHUNK = BRFC_MAX_CHUNK
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_size[6:0], partial_ok[7], peek[8], data_byte[16:9]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // ok[0], granted_count[7:1], out_byte[15:8],
                                  // used_count[26:16], free_count[37:27]
  output logic        out_tuser,  // has_data
  output logic        out_tlast
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (FILL_W > REQ_W) ? FILL_W : REQ_W;
  localparam int CNT_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

  kind_t             in_kind;
  logic [REQ_W-1:0]  in_req;
  logic              in_partial;
  logic              in_peek;
  logic [BYTE_W-1:0] in_byte;

  assign in_kind    = kind_t'(in_tuser);
  assign in_req     = in_tdata[6:0];
  assign in_partial = in_tdata[7];
  assign in_peek    = in_tdata[8];
  assign in_byte    = in_tdata[16:9];

  state_t            st_r, st_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  scan_r, scan_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [REQ_W-1:0]  pend_r, pend_nxt;
  logic [REQ_W-1:0]  grant_r, grant_nxt;
  logic [REQ_W-1:0]  cnt_r, cnt_nxt;
  logic              peek_r, peek_nxt;

  logic              out_valid_r;
  logic              ok_r;
  logic [REQ_W-1:0]  gcnt_r;
  logic              has_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              last_r;
  logic [COUNT_W-1:0] used_r;
  logic [COUNT_W-1:0] free_r;

  logic              ld;
  logic              ld_ok;
  logic [REQ_W-1:0]  ld_grant;
  logic              ld_has;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_last;
  logic [FILL_W-1:0] ld_fill;
  logic [CNT_W-1:0]  ld_used_x;
  logic [CNT_W-1:0]  ld_free_x;

  logic              wr_en;
  logic              rd_en;
  logic [BYTE_W-1:0] rd_data;

  logic              out_free;
  logic              in_acc;
  logic [REQ_W-1:0]  req_sat;
  logic [FILL_W-1:0] avail;
  logic              t_ok;
  logic [REQ_W-1:0]  t_grant;
  logic              fin;

  assign out_free  = out_tready || !out_valid_r;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // shared trim: saturate, then compare against the space or data on hand
  always_comb begin
    req_sat = (in_req > REQ_W'(MAX_CHUNK)) ? REQ_W'(MAX_CHUNK) : in_req;
    avail   = (in_kind == KIND_DEQ) ? fill_r : FILL_W'(CAPACITY) - fill_r;
    if (CMP_W'(avail) < CMP_W'(req_sat)) begin
      t_ok    = in_partial;
      t_grant = in_partial ? REQ_W'(avail) : '0;
    end else begin
      t_ok    = 1'b1;
      t_grant = req_sat;
    end
  end

  assign fin = (REQ_W'(cnt_r + 1'b1) == grant_r);

  always_comb begin
    st_nxt    = st_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    scan_nxt  = scan_r;
    fill_nxt  = fill_r;
    pend_nxt  = pend_r;
    grant_nxt = grant_r;
    cnt_nxt   = cnt_r;
    peek_nxt  = peek_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    ld        = 1'b0;
    ld_ok     = 1'b0;
    ld_grant  = '0;
    ld_has    = 1'b0;
    ld_byte   = '0;
    ld_last   = 1'b1;
    ld_fill   = fill_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_ENQ: begin
              pend_nxt = t_grant;
              ld       = 1'b1;
              ld_ok    = t_ok;
              ld_grant = t_grant;
            end
            KIND_DATA: begin
              ld = 1'b1;
              if (pend_r != '0 && fill_r < FILL_W'(CAPACITY)) begin
                wr_en    = 1'b1;
                wptr_nxt = wrap_inc(wptr_r);
                fill_nxt = FILL_W'(fill_r + 1'b1);
                pend_nxt = REQ_W'(pend_r - 1'b1);
                ld_ok    = 1'b1;
                ld_grant = REQ_W'(1);
                ld_fill  = fill_nxt;
              end
            end
            KIND_DEQ: begin
              if (t_grant == '0) begin
                ld       = 1'b1;
                ld_ok    = t_ok;
              end else begin
                grant_nxt = t_grant;
                cnt_nxt   = '0;
                scan_nxt  = rptr_r;
                peek_nxt  = in_peek;
                if (!in_peek) begin
                  fill_nxt = fill_r - FILL_W'(t_grant);
                end
                st_nxt = ST_RD;
              end
            end
            KIND_CLR: begin
              rptr_nxt = '0;
              wptr_nxt = '0;
              fill_nxt = '0;
              pend_nxt = '0;
              ld       = 1'b1;
              ld_ok    = 1'b1;
              ld_fill  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_en    = 1'b1;
        scan_nxt = wrap_inc(scan_r);
        st_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_ok    = 1'b1;
          ld_grant = grant_r;
          ld_has   = 1'b1;
          ld_byte  = rd_data;
          ld_last  = fin;
          cnt_nxt  = REQ_W'(cnt_r + 1'b1);
          if (fin) begin
            st_nxt = ST_IDLE;
            if (!peek_r) begin
              rptr_nxt = scan_r;
            end
          end else begin
            st_nxt = ST_RD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign ld_used_x = CNT_W'(ld_fill);
  assign ld_free_x = CNT_W'(FILL_W'(CAPACITY) - ld_fill);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rptr_r      <= '0;
      wptr_r      <= '0;
      fill_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    grant_r <= grant_nxt;
    cnt_r   <= cnt_nxt;
    peek_r  <= peek_nxt;
    if (ld) begin
      ok_r    <= ld_ok;
      gcnt_r  <= ld_grant;
      has_r   <= ld_has;
      obyte_r <= ld_byte;
      last_r  <= ld_last;
      used_r  <= ld_used_x[COUNT_W-1:0];
      free_r  <= ld_free_x[COUNT_W-1:0];
    end
  end

  brfc_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wptr_r),
    .wr_data(in_byte),
    .rd_en  (rd_en),
    .rd_addr(scan_r),
    .rd_data(rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = has_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, free_r, used_r, obyte_r, gcnt_r, ok_r};

endmodule

// ----- verif/byte_ring_fifo_chunked_unit_tb.sv -----
`timescale 1ns / 1ps

module byte_ring_fifo_chunked_unit_tb
  import brfc_pkg::*;
();

  localparam int CAP            = BRFC_CAPACITY;
  localparam int MAXC           = BRFC_MAX_CHUNK;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic        ok;
    logic [6:0]  granted;
    logic        has_data;
    logic [7:0]  data;
    logic        last;
    logic [10:0] used;
    logic [10:0] free;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // request_size[6:0], partial_ok[7], peek[8], data_byte[16:9]
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // ok[0], granted_count[7:1], out_byte[15:8],
                                // used_count[26:16], free_count[37:27]
  logic        out_tuser;       // has_data
  logic        out_tlast;

  // predictor state
  logic [7:0]   ring_mem [CAP];
  int           head_idx = 0;
  int           tail_idx = 0;
  int           fill_level = 0;
  int           writes_left = 0;
  fifo_result_t expected_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  fifo_result_t got_r;
  fifo_result_t exp_r;

  always #4 clk = ~clk;

  byte_ring_fifo_chunked_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  function automatic int trim_grant(int asked, int avail, bit partial, output logic ok);
    ok = 1'b1;
    if (avail < asked) begin
      if (partial) return avail;
      ok = 1'b0;
      return 0;
    end
    return asked;
  endfunction

  task automatic push_result(logic ok, int granted, logic has_data, logic [7:0] data,
                             logic last);
    fifo_result_t r;
    r.ok       = ok;
    r.granted  = granted[6:0];
    r.has_data = has_data;
    r.data     = data;
    r.last     = last;
    r.used     = fill_level[10:0];
    r.free     = 11'(CAP - fill_level);
    expected_results.push_back(r);
  endtask

  task automatic model_word(kind_t k, logic [6:0] req, logic partial, logic peek,
                            logic [7:0] data);
    int   asked;
    int   grant;
    int   start;
    logic ok;
    asked = (req > MAXC) ? MAXC : int'(req);
    case (k)
      KIND_ENQ: begin
        grant = trim_grant(asked, CAP - fill_level, partial, ok);
        writes_left = grant;
        push_result(ok, grant, 1'b0, 8'h00, 1'b1);
      end
      KIND_DATA: begin
        if (writes_left > 0 && fill_level < CAP) begin
          ring_mem[tail_idx] = data;
          tail_idx = (tail_idx + 1) % CAP;
          fill_level++;
          writes_left--;
          push_result(1'b1, 1, 1'b0, 8'h00, 1'b1);
        end else begin
          push_result(1'b0, 0, 1'b0, 8'h00, 1'b1);
        end
      end
      KIND_DEQ: begin
        grant = trim_grant(asked, fill_level, partial, ok);
        if (grant == 0) begin
          push_result(ok, 0, 1'b0, 8'h00, 1'b1);
        end else begin
          start = head_idx;
          if (!peek) begin
            head_idx = (head_idx + grant) % CAP;
            fill_level -= grant;
          end
          for (int i = 0; i < grant; i++)
            push_result(1'b1, grant, 1'b1, ring_mem[(start + i) % CAP], i == grant - 1);
        end
      end
      default: begin
        head_idx = 0;
        tail_idx = 0;
        fill_level = 0;
        writes_left = 0;
        push_result(1'b1, 0, 1'b0, 8'h00, 1'b1);
      end
    endcase
  endtask

  task automatic send_word(kind_t k, int req, bit partial, bit peek, int data);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {7'b0, data[7:0], peek, partial, req[6:0]};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    model_word(k, req[6:0], partial, peek, data[7:0]);
  endtask

  task automatic flag_field(string name, int exp_v, int act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      got_r.ok       = out_tdata[0];
      got_r.granted  = out_tdata[7:1];
      got_r.has_data = out_tuser;
      got_r.data     = out_tdata[15:8];
      got_r.last     = out_tlast;
      got_r.used     = out_tdata[26:16];
      got_r.free     = out_tdata[37:27];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got_r.ok !== exp_r.ok) flag_field("ok", exp_r.ok, got_r.ok);
        if (got_r.granted !== exp_r.granted)
          flag_field("granted_count", exp_r.granted, got_r.granted);
        if (got_r.has_data !== exp_r.has_data)
          flag_field("has_data", exp_r.has_data, got_r.has_data);
        if (got_r.data !== exp_r.data) flag_field("out_byte", exp_r.data, got_r.data);
        if (got_r.last !== exp_r.last) flag_field("last", exp_r.last, got_r.last);
        if (got_r.used !== exp_r.used) flag_field("used_count", exp_r.used, got_r.used);
        if (got_r.free !== exp_r.free) flag_field("free_count", exp_r.free, got_r.free);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_word(KIND_DATA, 0, 0, 0, 8'h5A);
    send_word(KIND_DEQ, 4, 0, 0, 0);
    send_word(KIND_DEQ, 4, 1, 0, 0);
    send_word(KIND_ENQ, 0, 0, 0, 0);
    send_word(KIND_ENQ, 127, 0, 0, 0);
    send_word(KIND_DATA, 0, 0, 0, 8'h00);
    send_word(KIND_DATA, 127, 1, 1, 8'hFF);
    send_word(KIND_DATA, 0, 0, 0, 8'hA5);
    send_word(KIND_ENQ, 3, 0, 0, 0);
    send_word(KIND_DATA, 0, 0, 0, 8'h11);
    send_word(KIND_DATA, 0, 0, 0, 8'h22);
    send_word(KIND_DATA, 0, 0, 0, 8'h33);
    send_word(KIND_DATA, 0, 0, 0, 8'h44);
    send_word(KIND_DEQ, 2, 0, 1, 0);
    send_word(KIND_DEQ, 10, 0, 0, 0);
    send_word(KIND_DEQ, 127, 1, 0, 8'hFF);
    send_word(KIND_ENQ, 5, 0, 0, 0);
    send_word(KIND_DATA, 0, 0, 0, 8'h81);
    send_word(KIND_CLR, 0, 0, 0, 0);
    send_word(KIND_DATA, 0, 0, 0, 8'h7E);
    send_word(KIND_DEQ, 1, 1, 0, 0);
    send_word(KIND_CLR, 127, 1, 1, 8'hFF);
  endtask

  task automatic test_max_chunk();
    send_word(KIND_CLR, 0, 0, 0, 0);
    send_word(KIND_ENQ, MAXC, 0, 0, 0);
    repeat (MAXC) send_word(KIND_DATA, 0, 0, 0, $urandom);
    send_word(KIND_DEQ, MAXC, 0, 1, 0);
    send_word(KIND_DEQ, 100, 0, 0, 0);
    send_word(KIND_DEQ, 1, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    int n;
    hold_left = 400;
    send_word(KIND_ENQ, 16, 1, 0, 0);
    n = writes_left;
    repeat (n) send_word(KIND_DATA, 0, 0, 0, $urandom);
    for (int i = 0; i < 4; i++) send_word(KIND_DEQ, 8, 1, i % 2, 0);
  endtask

  task automatic random_transaction();
    int pick;
    int size;
    int n;
    pick = $urandom_range(99);
    if (pick < 45) begin
      size = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 16);
      send_word(KIND_ENQ, size, $urandom_range(1), $urandom_range(1), $urandom);
      n = writes_left;
      if ($urandom_range(9) == 0) n = n + $urandom_range(1, 3);
      else if ($urandom_range(9) == 0 && n > 0) n = n - 1;
      repeat (n)
        send_word(KIND_DATA, $urandom_range(127), $urandom_range(1), $urandom_range(1),
                  $urandom);
    end else if (pick < 85) begin
      size = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(20);
      send_word(KIND_DEQ, size, $urandom_range(9) < 7, $urandom_range(3) == 0, $urandom);
    end else if (pick < 96) begin
      send_word(KIND_DATA, $urandom_range(127), $urandom_range(1), $urandom_range(1),
                $urandom);
    end else begin
      send_word(KIND_CLR, $urandom_range(127), $urandom_range(1), $urandom_range(1),
                $urandom);
    end
  endtask

  task automatic test_random_phase(int idle, int stall, int words);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    while (words_sent - start < words) random_transaction();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_max_chunk();
    test_backpressure();
    test_random_phase(0, 0, 25);
    test_random_phase(86, 0, 25);
    test_random_phase(0, 86, 24);
    test_random_phase(22, 22, 24);
    idle_pct  = 0;
    stall_pct = 0;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run sent %0d words and checked %0d result words: corner requests, a full-size",
             words_sent, results_checked);
    $display("chunk peeked and drained, a long output stall, and random traffic in four mixes.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/brfc_pkg.sv
design/brfc_store.sv
design/byte_ring_fifo_chunked_unit.sv
verif/byte_ring_fifo_chunked_unit_tb.sv
